>>> sv/mmds_pkg.sv
// Package for the 2x mipmap downsampler: shared constants, register
// indexes, control structs and the byte averaging function. No dependencies.
`timescale 1ns / 1ps

package mmds_pkg;

   localparam int CHAN_BITS      = 8;
   localparam int COUNT_BITS     = 13;
   localparam int LOG2_BITS      = 4;
   localparam int LOG2_LIMIT     = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SRC_WIDTH_LOG2  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SRC_HEIGHT_LOG2 = 2'd1;

   // Per-word control carried from the address stage to the averaging stage.
   typedef struct packed {
      logic use_v;   // average with the line store entry
      logic use_h;   // average with the held left half
      logic hold;    // keep this result as the left half
      logic emit;    // this word produces an output pixel
      logic last;    // final pixel of the new level
   } stage_ctrl_type;

   // Control fanned out to every channel lane.
   typedef struct packed {
      logic adv;
      logic clr;
      logic use_v;
      logic use_h;
      logic hold;
   } lane_ctrl_type;

   function automatic logic [CHAN_BITS-1:0] avg_byte(input logic [CHAN_BITS-1:0] p,
                                                     input logic [CHAN_BITS-1:0] q);
      logic [CHAN_BITS:0] sum;
      sum = {1'b0, p} + {1'b0, q};
      return sum[CHAN_BITS:1];
   endfunction

endpackage

>>> sv/mmds_req_if.sv
// Input pixel channel of the mipmap downsampler: valid/ready plus four
// channel bytes. Depends on mmds_pkg.
`timescale 1ns / 1ps

interface mmds_req_if;
   logic                          valid;
   logic                          ready;
   logic [mmds_pkg::CHAN_BITS-1:0] chan_a;
   logic [mmds_pkg::CHAN_BITS-1:0] chan_b;
   logic [mmds_pkg::CHAN_BITS-1:0] chan_c;
   logic [mmds_pkg::CHAN_BITS-1:0] chan_d;

   modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
   modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

>>> sv/mmds_rsp_if.sv
// Result pixel channel of the mipmap downsampler: valid/ready, four channel
// bytes and the level end flag. Depends on mmds_pkg.
`timescale 1ns / 1ps

interface mmds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mmds_pkg::CHAN_BITS-1:0] out_a;
   logic [mmds_pkg::CHAN_BITS-1:0] out_b;
   logic [mmds_pkg::CHAN_BITS-1:0] out_c;
   logic [mmds_pkg::CHAN_BITS-1:0] out_d;
   logic                          level_end;

   modport source (output valid, out_a, out_b, out_c, out_d, level_end, input ready);
   modport sink (input valid, out_a, out_b, out_c, out_d, level_end, output ready);
endinterface

>>> sv/mmds_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module mmds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/mmds_lane.sv
// One channel lane of the mipmap downsampler: vertical average, held left
// half and horizontal average for a single byte. Depends on mmds_pkg.
`timescale 1ns / 1ps

module mmds_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  mmds_pkg::lane_ctrl_type        ctrl,
   input  logic [mmds_pkg::CHAN_BITS-1:0] upper,
   input  logic [mmds_pkg::CHAN_BITS-1:0] lower,
   output logic [mmds_pkg::CHAN_BITS-1:0] result
);

   logic [mmds_pkg::CHAN_BITS-1:0] half_ff;
   logic [mmds_pkg::CHAN_BITS-1:0] half_in;
   logic [mmds_pkg::CHAN_BITS-1:0] vert;

   assign vert   = ctrl.use_v ? mmds_pkg::avg_byte(upper, lower) : lower;
   assign result = ctrl.use_h ? mmds_pkg::avg_byte(half_ff, vert) : vert;

   always_comb begin
      half_in = half_ff;
      if (ctrl.clr) begin
         half_in = '0;
      end else if (ctrl.adv && ctrl.hold) begin
         half_in = vert;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= '0;
      end else begin
         half_ff <= half_in;
      end
   end

endmodule

>>> sv/mipmap_downsampler_2x.sv
// 2x2 box-filter mipmap downsampler, top level: config registers, raster
// counters, line store, channel lanes and output register.
// Depends on mmds_pkg, mmds_req_if, mmds_rsp_if, mmds_ram and mmds_lane.
// A result passes the averaging stage register, then the output register.
// Throughput: 1 source pixel per cycle when unstalled, set by the one read and
//   one write the line store takes per cycle and each lane's add and shift.
// Reset: synchronous, active high; clears counters, held halves, valid bits and
//   sets both log2 registers to 2. The line store is not cleared: every entry
//   is written on an even row before the odd row reads it.
`timescale 1ns / 1ps

module mipmap_downsampler_2x #(
   parameter int MAX_WIDTH = 4096,
   parameter int CHANNELS  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mmds_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mmds_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   mmds_req_if.sink                            req_chan,
   mmds_rsp_if.source                          rsp_chan
);

   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam int PIX_BITS  = CHANNELS * mmds_pkg::CHAN_BITS;
   // Largest log2 whose power of two still fits the line store.
   localparam int MAX_LOG2  = $clog2(MAX_WIDTH + 1) - 1;
   localparam int CB        = mmds_pkg::CHAN_BITS;
   localparam int NB        = mmds_pkg::COUNT_BITS;

   // ---------------------------------------------------------------
   // Configuration registers; a listed write restarts the image.
   // ---------------------------------------------------------------
   logic [mmds_pkg::LOG2_BITS-1:0] width_log2_ff;
   logic [mmds_pkg::LOG2_BITS-1:0] height_log2_ff;
   logic                           cfg_clr;

   assign cfg_clr = csr_we && (csr_index == mmds_pkg::REG_SRC_WIDTH_LOG2 ||
                               csr_index == mmds_pkg::REG_SRC_HEIGHT_LOG2);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= 4'd2;
         height_log2_ff <= 4'd2;
      end else if (csr_we) begin
         case (csr_index)
            mmds_pkg::REG_SRC_WIDTH_LOG2:  width_log2_ff  <= csr_wdata;
            mmds_pkg::REG_SRC_HEIGHT_LOG2: height_log2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the log2 values: height at the limit, width also to the store.
   logic [mmds_pkg::LOG2_BITS-1:0] wl_lim;
   logic [mmds_pkg::LOG2_BITS-1:0] wl;
   logic [mmds_pkg::LOG2_BITS-1:0] hl;
   logic [NB-1:0]                  w_mask;
   logic [NB-1:0]                  h_mask;

   always_comb begin
      wl_lim = (width_log2_ff > 4'(mmds_pkg::LOG2_LIMIT)) ?
               4'(mmds_pkg::LOG2_LIMIT) : width_log2_ff;
      wl     = (wl_lim > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : wl_lim;
      hl     = (height_log2_ff > 4'(mmds_pkg::LOG2_LIMIT)) ?
               4'(mmds_pkg::LOG2_LIMIT) : height_log2_ff;
      w_mask = NB'((NB'(1) << wl) - NB'(1));
      h_mask = NB'((NB'(1) << hl) - NB'(1));
   end

   // ---------------------------------------------------------------
   // Handshake: averaging stage and output register.
   // ---------------------------------------------------------------
   logic                     s1_valid_ff;
   mmds_pkg::stage_ctrl_type s1_ctrl_ff;
   logic [PIX_BITS-1:0]      s1_pix_ff;
   logic                     rsp_valid_ff;
   logic [PIX_BITS-1:0]      rsp_pix_ff;
   logic                     rsp_last_ff;
   logic                     out_free;
   logic                     s1_adv;
   logic                     req_acc;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   // A word that emits nothing leaves the stage even while the output stalls.
   assign s1_adv         = s1_valid_ff && (!s1_ctrl_ff.emit || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_acc        = req_chan.valid && req_chan.ready;

   // ---------------------------------------------------------------
   // Raster counters and per-word decode.
   // ---------------------------------------------------------------
   logic [NB-1:0]            col_ff;
   logic [NB-1:0]            row_ff;
   logic [NB-1:0]            col_in;
   logic [NB-1:0]            row_in;
   logic [NB-1:0]            col_cur;
   logic [NB-1:0]            row_cur;
   logic                     col_end;
   logic                     row_end;
   mmds_pkg::stage_ctrl_type dec_ctrl;
   logic                     ram_we;
   logic                     ram_re;

   always_comb begin
      // Drop stale counts beyond the current image size.
      col_cur = ((col_ff & ~w_mask) != '0) ? '0 : col_ff;
      row_cur = ((row_ff & ~h_mask) != '0) ? '0 : row_ff;
      col_end = (col_cur == w_mask);
      row_end = (row_cur == h_mask);

      col_in = col_ff;
      row_in = row_ff;
      if (cfg_clr) begin
         col_in = '0;
         row_in = '0;
      end else if (req_acc) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : NB'(row_cur + NB'(1));
         end else begin
            col_in = NB'(col_cur + NB'(1));
            row_in = row_cur;
         end
      end

      dec_ctrl = '0;
      if (hl == '0) begin
         if (wl != '0) begin
            // single row: horizontal pairs only
            dec_ctrl.use_h = 1'b1;
            dec_ctrl.hold  = !col_cur[0];
            dec_ctrl.emit  = col_cur[0];
            dec_ctrl.last  = col_end;
         end
      end else if (wl == '0) begin
         // single column: vertical pairs only
         dec_ctrl.use_v = row_cur[0];
         dec_ctrl.emit  = row_cur[0];
         dec_ctrl.last  = row_end;
      end else if (row_cur[0]) begin
         dec_ctrl.use_v = 1'b1;
         dec_ctrl.use_h = 1'b1;
         dec_ctrl.hold  = !col_cur[0];
         dec_ctrl.emit  = col_cur[0];
         dec_ctrl.last  = row_end && col_end;
      end

      // Even rows fill the line store, odd rows read it back.
      ram_we = req_acc && (hl != '0) && !row_cur[0];
      ram_re = req_acc && (hl != '0) && row_cur[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Assemble the source word from the channels in use.
   logic [CB-1:0]       in_byte [4];
   logic [PIX_BITS-1:0] req_pix;

   assign in_byte[0] = req_chan.chan_a;
   assign in_byte[1] = req_chan.chan_b;
   assign in_byte[2] = req_chan.chan_c;
   assign in_byte[3] = req_chan.chan_d;

   for (genvar k = 0; k < CHANNELS; k++) begin : g_in
      assign req_pix[k*CB +: CB] = in_byte[k];
   end

   // ---------------------------------------------------------------
   // Line store: one write and one read per cycle, read data registered.
   // ---------------------------------------------------------------
   logic [PIX_BITS-1:0] ram_rd_data;

   mmds_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (col_cur[ADDR_BITS-1:0]),
      .wr_data (req_pix),
      .rd_en   (ram_re),
      .rd_addr (col_cur[ADDR_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // Advance the averaging stage; hold the word while its result waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ctrl_ff <= dec_ctrl;
         s1_pix_ff  <= req_pix;
      end
   end

   // ---------------------------------------------------------------
   // Channel lanes, side by side.
   // ---------------------------------------------------------------
   mmds_pkg::lane_ctrl_type lane_ctrl;
   logic [PIX_BITS-1:0]     lane_out;

   assign lane_ctrl.adv   = s1_adv;
   assign lane_ctrl.clr   = cfg_clr;
   assign lane_ctrl.use_v = s1_ctrl_ff.use_v;
   assign lane_ctrl.use_h = s1_ctrl_ff.use_h;
   assign lane_ctrl.hold  = s1_ctrl_ff.hold;

   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      mmds_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .upper  (ram_rd_data[k*CB +: CB]),
         .lower  (s1_pix_ff[k*CB +: CB]),
         .result (lane_out[k*CB +: CB])
      );
   end

   // ---------------------------------------------------------------
   // Merge the lanes into the output register.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff && s1_ctrl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff && s1_ctrl_ff.emit) begin
         rsp_pix_ff  <= lane_out;
         rsp_last_ff <= s1_ctrl_ff.last;
      end
   end

   // Channels above the configured count read as zero.
   logic [CB-1:0] out_byte [4];

   for (genvar k = 0; k < 4; k++) begin : g_out
      if (k < CHANNELS) begin : g_used
         assign out_byte[k] = rsp_pix_ff[k*CB +: CB];
      end else begin : g_unused
         assign out_byte[k] = '0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_a     = out_byte[0];
   assign rsp_chan.out_b     = out_byte[1];
   assign rsp_chan.out_c     = out_byte[2];
   assign rsp_chan.out_d     = out_byte[3];
   assign rsp_chan.level_end = rsp_last_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_ram_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("line store written and read by the same word");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_pix_ff) &&
                                 $stable(s1_ctrl_ff))
      else $error("averaging stage changed while stalled");

   a_ready_busy: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && s1_ctrl_ff.emit && rsp_valid_ff)
      else $error("input stalled without a blocked result");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_clr |=> col_ff == '0 && row_ff == '0)
      else $error("configuration write did not restart the image");

endmodule
